### rtl/ims_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ims_pkg
// Shared constants for the island Moran birth-death step unit.
// ----------------------------------------------------------------------------
package ims_pkg;

    localparam int DEMES  = 16;
    localparam int DEME_W = $clog2(DEMES);
    localparam int FEC_W  = 46;
    localparam int CUM_W  = FEC_W + $clog2(2 * DEMES);

    localparam int NUM_W  = 34;
    localparam int DEN_W  = 10;

    // reciprocal of DEMES - 1 for the migration weight of the other demes
    localparam int          MIG_SHIFT = 35;
    localparam logic [32:0] MIG_RECIP = 33'(((64'd1 << MIG_SHIFT) + 64'(DEMES) - 64'd2)
                                            / 64'(DEMES - 1));

    localparam logic [2:0] REG_SEL_STRENGTH = 3'd0;
    localparam logic [2:0] REG_HELP_COST    = 3'd1;
    localparam logic [2:0] REG_HELP_BENEFIT = 3'd2;
    localparam logic [2:0] REG_MIG_PROB     = 3'd3;
    localparam logic [2:0] REG_MUT_PROB     = 3'd4;
    localparam logic [2:0] REG_MUT_BIAS     = 3'd5;
    localparam logic [2:0] REG_EXCL_SELF    = 3'd6;
    localparam logic [2:0] REG_DEME_SIZE    = 3'd7;

endpackage
`default_nettype wire

### rtl/island_moran_birth_death_step_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// island_moran_birth_death_step_unit
// Per-deme type-A counts with load and birth-death microstep commands.
// ----------------------------------------------------------------------------
// A load word writes the count; its result strobes on done in the next
// cycle and busy never rises. A step word runs through one shared multiplier
// and one bit-serial divider: two divisions per deme set the fecundities,
// then a roulette walk over the fecundities picks the birth and a walk over
// the demes picks the death. The result is on the ports for one cycle with
// done high and must be taken then; a new start is accepted in that same cycle.
// ----------------------------------------------------------------------------
module island_moran_birth_death_step_unit
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         mode,
    input  wire  [3:0]  deme_index,
    input  wire  [9:0]  load_count,
    input  wire  [31:0] birth_draw,
    input  wire  [31:0] death_deme_draw,
    input  wire  [31:0] death_member_draw,
    input  wire  [31:0] mutation_draw,
    input  wire  [31:0] mutant_type_draw,
    output logic        done,
    output logic [3:0]  birth_deme,
    output logic        offspring_type,
    output logic [3:0]  death_deme,
    output logic        dead_type,
    output logic [9:0]  deme_count_after,
    output logic [13:0] total_type_a,
    output logic        fecundity_clamped,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [31:0] cfg_data
);
    import ims_pkg::*;

    localparam int J_W = DEME_W + 1;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_SC0  = 5'd1;
    localparam logic [4:0] ST_SC1  = 5'd2;
    localparam logic [4:0] ST_SC2  = 5'd3;
    localparam logic [4:0] ST_SB1  = 5'd4;
    localparam logic [4:0] ST_SB2  = 5'd5;
    localparam logic [4:0] ST_D0   = 5'd6;
    localparam logic [4:0] ST_D1   = 5'd7;
    localparam logic [4:0] ST_D2   = 5'd8;
    localparam logic [4:0] ST_D3   = 5'd9;
    localparam logic [4:0] ST_D4   = 5'd10;
    localparam logic [4:0] ST_D5   = 5'd11;
    localparam logic [4:0] ST_D6   = 5'd12;
    localparam logic [4:0] ST_D7   = 5'd13;
    localparam logic [4:0] ST_D8   = 5'd14;
    localparam logic [4:0] ST_D9   = 5'd15;
    localparam logic [4:0] ST_D10  = 5'd16;
    localparam logic [4:0] ST_R0   = 5'd17;
    localparam logic [4:0] ST_R1   = 5'd18;
    localparam logic [4:0] ST_R2   = 5'd19;
    localparam logic [4:0] ST_R3   = 5'd20;
    localparam logic [4:0] ST_R4   = 5'd21;
    localparam logic [4:0] ST_B0   = 5'd22;
    localparam logic [4:0] ST_B1   = 5'd23;
    localparam logic [4:0] ST_M0   = 5'd24;
    localparam logic [4:0] ST_K    = 5'd26;
    localparam logic [4:0] ST_T0   = 5'd27;
    localparam logic [4:0] ST_T1   = 5'd28;
    localparam logic [4:0] ST_T2   = 5'd29;

    // configuration
    logic [15:0] sel_reg;
    logic [23:0] cost_reg;
    logic [23:0] ben_reg;
    logic [31:0] mig_reg;
    logic [31:0] mutp_reg;
    logic [31:0] bias_reg;
    logic        excl_reg;
    logic [9:0]  size_reg;

    // state
    logic [9:0]  cnt_reg [DEMES];
    logic [13:0] total_reg;
    logic [4:0]  state_reg, state_next;

    // datapath
    logic [31:0]        bdraw_reg, ddraw_reg, mdraw_reg, mudraw_reg, tdraw_reg;
    logic [23:0]        sc_reg, sc_next, sb_reg, sb_next;
    logic [DEME_W-1:0]  i_reg, i_next;
    logic [J_W-1:0]     j_reg, j_next;
    logic [9:0]         n_reg, n_next;
    logic [NUM_W-1:0]   qa_reg, qa_next, qb_reg, qb_next;
    logic [CUM_W-1:0]   cum_reg, cum_next;
    logic [CUM_W-1:0]   run_reg, run_next;
    logic [CUM_W-1:0]   r_reg, r_next;
    logic [31:0]        part_reg, part_next;
    logic [31:0]        other_reg, other_next;
    logic               clamp_reg, clamp_next;
    logic [DEME_W-1:0]  bdeme_reg, bdeme_next;
    logic               btype_reg, btype_next;
    logic [DEME_W-1:0]  ddeme_reg, ddeme_next;

    // shared multiplier
    logic signed [36:0] a_reg, a_next;
    logic signed [32:0] b_reg, b_next;
    logic signed [69:0] prod_reg;

    // fecundity store
    logic [FEC_W-1:0]   fec_mem [2 * DEMES];
    logic [FEC_W-1:0]   fec_rd_reg;
    logic               fec_we;
    logic [J_W-1:0]     fec_waddr;
    logic [FEC_W-1:0]   fec_wdata;

    // divider
    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic               div_done;
    logic [NUM_W-1:0]   div_quo;

    // result
    logic        done_reg, done_next;
    logic [3:0]  res_bdeme_reg, res_bdeme_next;
    logic        res_otype_reg, res_otype_next;
    logic [3:0]  res_ddeme_reg, res_ddeme_next;
    logic        res_dtype_reg, res_dtype_next;
    logic [9:0]  res_cnt_reg, res_cnt_next;
    logic        res_clamp_reg, res_clamp_next;

    // count updates
    logic              cnt_we;
    logic [DEME_W-1:0] cnt_waddr;
    logic [9:0]        cnt_wdata;
    logic [13:0]       total_next;

    // scratch
    logic              accept;
    logic [9:0]        cur_n;
    logic [DEN_W-1:0]  den_eff;
    logic [10:0]        n_minus_e;
    logic signed [10:0] size_minus_n;
    logic signed [36:0] term_a;
    logic [CUM_W-1:0]   run_sum;
    logic [32:0]        drun_sum;
    logic [9:0]         sat_cnt;
    logic               dtype;
    logic               newtype;
    logic [9:0]         n_after;

    ims_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;

    assign den_eff      = (excl_reg && size_reg == '0) ? '0 : size_reg - {9'd0, excl_reg};
    assign n_minus_e    = {1'b0, n_reg} - {10'd0, excl_reg};
    assign size_minus_n = $signed({1'b0, size_reg}) - $signed({1'b0, n_reg});
    assign term_a       = 37'sd65536 - $signed(37'(sc_reg)) + $signed(37'(qa_reg));
    assign run_sum      = run_reg + CUM_W'(fec_rd_reg);
    assign drun_sum     = run_reg[32:0] + ((i_reg == bdeme_reg) ?
                          (33'h1_0000_0000 - {1'b0, mig_reg}) : {1'b0, other_reg});
    assign sat_cnt      = (load_count > size_reg) ? size_reg : load_count;
    assign dtype        = prod_reg[41:0] < {n_reg, 32'd0};
    assign newtype      = (mudraw_reg < mutp_reg) ? (tdraw_reg < bias_reg) : btype_reg;
    assign n_after      = n_reg - {9'd0, dtype} + {9'd0, newtype};

    always_comb
    begin
        cur_n = cnt_reg[i_reg];
        if (state_reg == ST_T0)
        begin
            cur_n = cnt_reg[ddeme_reg];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sc_next        = sc_reg;
        sb_next        = sb_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        qa_next        = qa_reg;
        qb_next        = qb_reg;
        cum_next       = cum_reg;
        run_next       = run_reg;
        r_next         = r_reg;
        part_next      = part_reg;
        other_next     = other_reg;
        clamp_next     = clamp_reg;
        bdeme_next     = bdeme_reg;
        btype_next     = btype_reg;
        ddeme_next     = ddeme_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        fec_we         = 1'b0;
        fec_waddr      = {i_reg, 1'b0};
        fec_wdata      = '0;
        div_start      = 1'b0;
        div_num        = prod_reg[NUM_W-1:0];
        div_den        = den_eff;
        cnt_we         = 1'b0;
        cnt_waddr      = ddeme_reg;
        cnt_wdata      = n_after;
        total_next     = total_reg;
        done_next      = 1'b0;
        res_bdeme_next = res_bdeme_reg;
        res_otype_next = res_otype_reg;
        res_ddeme_next = res_ddeme_reg;
        res_dtype_next = res_dtype_reg;
        res_cnt_next   = res_cnt_reg;
        res_clamp_next = res_clamp_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!mode)
                    begin
                        done_next      = 1'b1;
                        res_bdeme_next = '0;
                        res_otype_next = 1'b0;
                        res_ddeme_next = '0;
                        res_dtype_next = 1'b0;
                        res_clamp_next = 1'b0;
                        res_cnt_next   = '0;
                        if (32'(deme_index) < DEMES)
                        begin
                            cnt_we       = 1'b1;
                            cnt_waddr    = DEME_W'(deme_index);
                            cnt_wdata    = sat_cnt;
                            total_next   = total_reg - 14'(cnt_reg[DEME_W'(deme_index)])
                                           + 14'(sat_cnt);
                            res_cnt_next = sat_cnt;
                        end
                    end
                    else
                    begin
                        a_next     = $signed(37'(sel_reg));
                        b_next     = $signed(33'(cost_reg));
                        cum_next   = '0;
                        clamp_next = 1'b0;
                        i_next     = '0;
                        state_next = ST_SC0;
                    end
                end
            end
            ST_SC0: state_next = ST_SC1;
            ST_SC1: state_next = ST_SC2;
            ST_SC2:
            begin
                sc_next    = prod_reg[39:16];
                a_next     = $signed(37'(sel_reg));
                b_next     = $signed(33'(ben_reg));
                state_next = ST_SB1;
            end
            ST_SB1: state_next = ST_SB2;
            ST_SB2:
            begin
                sb_next    = prod_reg[39:16];
                state_next = ST_D0;
            end
            ST_D0:
            begin
                n_next     = cur_n;
                state_next = ST_D1;
            end
            ST_D1:
            begin
                a_next     = $signed(37'(sb_reg));
                b_next     = (n_reg == '0) ? '0 : $signed(33'(n_minus_e));
                state_next = ST_D2;
            end
            ST_D2: state_next = ST_D3;
            ST_D3:
            begin
                div_start  = 1'b1;
                a_next     = $signed(37'(sb_reg));
                b_next     = $signed(33'(n_reg));
                state_next = ST_D4;
            end
            ST_D4:
            begin
                if (div_done)
                begin
                    qa_next    = div_quo;
                    state_next = ST_D5;
                end
            end
            ST_D5:
            begin
                div_start  = 1'b1;
                state_next = ST_D6;
            end
            ST_D6:
            begin
                if (div_done)
                begin
                    qb_next    = div_quo;
                    a_next     = term_a;
                    b_next     = $signed(33'(n_reg));
                    state_next = ST_D7;
                end
            end
            ST_D7:
            begin
                a_next     = $signed(37'(17'd65536) + 37'(qb_reg));
                b_next     = {{22{size_minus_n[10]}}, size_minus_n};
                state_next = ST_D8;
            end
            ST_D8:
            begin
                fec_we    = 1'b1;
                fec_waddr = {i_reg, 1'b0};
                if (prod_reg[69])
                begin
                    clamp_next = 1'b1;
                end
                else
                begin
                    fec_wdata = prod_reg[FEC_W-1:0];
                    cum_next  = cum_reg + CUM_W'(prod_reg[FEC_W-1:0]);
                end
                state_next = ST_D9;
            end
            ST_D9:
            begin
                fec_we    = 1'b1;
                fec_waddr = {i_reg, 1'b1};
                if (prod_reg[69])
                begin
                    clamp_next = 1'b1;
                end
                else
                begin
                    fec_wdata = prod_reg[FEC_W-1:0];
                    cum_next  = cum_reg + CUM_W'(prod_reg[FEC_W-1:0]);
                end
                state_next = ST_D10;
            end
            ST_D10:
            begin
                if (i_reg == DEME_W'(DEMES - 1))
                begin
                    state_next = ST_R0;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_D0;
                end
            end
            ST_R0:
            begin
                a_next     = $signed(37'(bdraw_reg));
                b_next     = $signed(33'(cum_reg[31:0]));
                state_next = ST_R1;
            end
            ST_R1:
            begin
                a_next     = $signed(37'(bdraw_reg));
                b_next     = $signed(33'(cum_reg[CUM_W-1:32]));
                state_next = ST_R2;
            end
            ST_R2:
            begin
                part_next  = prod_reg[63:32];
                state_next = ST_R3;
            end
            ST_R3:
            begin
                r_next     = CUM_W'(prod_reg[CUM_W-1:0]) + CUM_W'(part_reg);
                run_next   = '0;
                j_next     = '0;
                a_next     = $signed(37'(mig_reg));
                b_next     = $signed(MIG_RECIP);
                state_next = ST_B0;
            end
            ST_R4: state_next = ST_B0;
            ST_B0: state_next = ST_B1;
            ST_B1:
            begin
                run_next = run_sum;
                if (r_reg < run_sum)
                begin
                    bdeme_next = j_reg[J_W-1:1];
                    btype_next = ~j_reg[0];
                    state_next = ST_M0;
                end
                else if (j_reg == J_W'(2 * DEMES - 1))
                begin
                    bdeme_next = DEME_W'(DEMES - 1);
                    btype_next = 1'b0;
                    state_next = ST_M0;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_B0;
                end
            end
            ST_M0:
            begin
                other_next = 32'(prod_reg[63:MIG_SHIFT]);
                run_next   = '0;
                i_next     = '0;
                state_next = ST_K;
            end
            ST_K:
            begin
                run_next = CUM_W'(drun_sum);
                if ({1'b0, ddraw_reg} < drun_sum || i_reg == DEME_W'(DEMES - 1))
                begin
                    ddeme_next = i_reg;
                    state_next = ST_T0;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_T0:
            begin
                n_next     = cur_n;
                a_next     = $signed(37'(mdraw_reg));
                b_next     = $signed(33'(size_reg));
                state_next = ST_T1;
            end
            ST_T1: state_next = ST_T2;
            ST_T2:
            begin
                cnt_we         = 1'b1;
                total_next     = total_reg - 14'(dtype) + 14'(newtype);
                done_next      = 1'b1;
                res_bdeme_next = 4'(bdeme_reg);
                res_otype_next = newtype;
                res_ddeme_next = 4'(ddeme_reg);
                res_dtype_next = dtype;
                res_cnt_next   = n_after;
                res_clamp_next = clamp_reg;
                state_next     = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= '0;
            cost_reg  <= '0;
            ben_reg   <= '0;
            mig_reg   <= '0;
            mutp_reg  <= '0;
            bias_reg  <= 32'h8000_0000;
            excl_reg  <= 1'b0;
            size_reg  <= 10'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SEL_STRENGTH: sel_reg  <= cfg_data[15:0];
                REG_HELP_COST:    cost_reg <= cfg_data[23:0];
                REG_HELP_BENEFIT: ben_reg  <= cfg_data[23:0];
                REG_MIG_PROB:     mig_reg  <= cfg_data;
                REG_MUT_PROB:     mutp_reg <= cfg_data;
                REG_MUT_BIAS:     bias_reg <= cfg_data;
                REG_EXCL_SELF:    excl_reg <= cfg_data[0];
                REG_DEME_SIZE:    size_reg <= cfg_data[9:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            done_reg  <= 1'b0;
            for (int k = 0; k < DEMES; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            done_reg  <= done_next;
            if (cnt_we)
            begin
                cnt_reg[cnt_waddr] <= cnt_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bdraw_reg  <= birth_draw;
            ddraw_reg  <= death_deme_draw;
            mdraw_reg  <= death_member_draw;
            mudraw_reg <= mutation_draw;
            tdraw_reg  <= mutant_type_draw;
        end
        sc_reg        <= sc_next;
        sb_reg        <= sb_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        n_reg         <= n_next;
        qa_reg        <= qa_next;
        qb_reg        <= qb_next;
        cum_reg       <= cum_next;
        run_reg       <= run_next;
        r_reg         <= r_next;
        part_reg      <= part_next;
        other_reg     <= other_next;
        clamp_reg     <= clamp_next;
        bdeme_reg     <= bdeme_next;
        btype_reg     <= btype_next;
        ddeme_reg     <= ddeme_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        prod_reg      <= a_reg * b_reg;
        res_bdeme_reg <= res_bdeme_next;
        res_otype_reg <= res_otype_next;
        res_ddeme_reg <= res_ddeme_next;
        res_dtype_reg <= res_dtype_next;
        res_cnt_reg   <= res_cnt_next;
        res_clamp_reg <= res_clamp_next;
    end

    always_ff @(posedge clk)
    begin
        if (fec_we)
        begin
            fec_mem[fec_waddr] <= fec_wdata;
        end
        fec_rd_reg <= fec_mem[j_reg];
    end

    assign done              = done_reg;
    assign birth_deme        = res_bdeme_reg;
    assign offspring_type    = res_otype_reg;
    assign death_deme        = res_ddeme_reg;
    assign dead_type         = res_dtype_reg;
    assign deme_count_after  = res_cnt_reg;
    assign total_type_a      = total_reg;
    assign fecundity_clamped = res_clamp_reg;

endmodule
`default_nettype wire

### rtl/ims_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ims_div
// Restoring unsigned divider, one quotient bit per cycle. A zero divisor
// gives a zero quotient.
// ----------------------------------------------------------------------------
module ims_div
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire [ims_pkg::NUM_W-1:0]     num,
    input  wire [ims_pkg::DEN_W-1:0]     den,
    output logic                         done,
    output logic [ims_pkg::NUM_W-1:0]    quo
);
    import ims_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic              run_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              zero_reg;
    logic              done_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W:0]    rem_sh;
    logic              ge;

    assign rem_sh = {rem_reg, quo_reg[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(NUM_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg  <= den;
            zero_reg <= (den == '0);
            rem_reg  <= '0;
            quo_reg  <= num;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = zero_reg ? '0 : quo_reg;

endmodule
`default_nettype wire
